// File: rtl/assert_macros.svh
// assertion macros for the rtl files, used by integer_field_formatter
// clocked on clk and disabled while rst_n is low, in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ifmt_pkg.sv
// shared types, codes and constants of the integer field formatter
// no dependencies
package ifmt_pkg;

  localparam int MAX_WIDTH         = 63;
  localparam int MAX_PRECISION     = 60;
  localparam int DIGIT_STORE_DEPTH = 22;
  localparam int DIGIT_IDX_W       = $clog2(DIGIT_STORE_DEPTH);
  localparam int DIGIT_CNT_W       = $clog2(DIGIT_STORE_DEPTH + 1);

  typedef logic [2:0] mode_t;
  localparam mode_t MODE_SDEC   = 3'd0;
  localparam mode_t MODE_UDEC   = 3'd1;
  localparam mode_t MODE_OCT    = 3'd2;
  localparam mode_t MODE_HEXL   = 3'd3;
  localparam mode_t MODE_HEXU   = 3'd4;
  localparam mode_t MODE_PTR    = 3'd5;
  localparam mode_t MODE_CHAR   = 3'd6;
  localparam mode_t MODE_UNUSED = 3'd7;

  typedef logic [1:0] size_class_t;
  localparam size_class_t SC_8  = 2'd0;
  localparam size_class_t SC_16 = 2'd1;
  localparam size_class_t SC_32 = 2'd2;
  localparam size_class_t SC_64 = 2'd3;

  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ALT   = 3;
  localparam int FLAG_ZERO  = 4;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_X       = 8'h78;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CONV,
    ST_SIZE,
    ST_BOUND,
    ST_EMIT
  } state_t;

  function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      return CH_ZERO + d8;
    end
    return (upper ? CH_UPPER_A : CH_LOWER_A) + d8 - 8'd10;
  endfunction

  function automatic logic [63:0] mask_size(logic [63:0] v, size_class_t sc);
    logic [63:0] r;
    unique case (sc)
      SC_8:    r = {56'b0, v[7:0]};
      SC_16:   r = {48'b0, v[15:0]};
      SC_32:   r = {32'b0, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/integer_field_formatter.sv
// integer field formatter: one integer conversion in, its characters out one per transfer
// states after the input transfer: load, conversion, size, bound, then emit; conversion takes n
// shift/add-3 steps (8/16/32/64 by size class) for decimal, one step per digit for octal and
// hex, and 0 for char or suppressed digits; the shared digit unit sets n, then one character per
// cycle while out_stall is low; a new conversion is taken in idle only; unused modes are dropped
// synchronous active-low reset returns the sequencer to idle and drops the output valid
`include "assert_macros.svh"

module integer_field_formatter import ifmt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [2:0]  in_mode,
  input  logic [1:0]  in_size_class,
  input  logic [4:0]  in_flag_bits,
  input  logic        in_width_given,
  input  logic [5:0]  in_field_width,
  input  logic        in_precision_given,
  input  logic [5:0]  in_precision,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last,
  output logic [6:0]  out_char_count
);

  // sequencer
  state_t state_r, state_nxt;

  // captured conversion
  logic [63:0]       work_r, work_nxt;     // raw value, then the shifting work value
  mode_t             mode_r, mode_nxt;
  size_class_t       sc_r, sc_nxt;
  logic [4:0]        flags_r, flags_nxt;
  logic              wg_r, wg_nxt;
  logic [5:0]        fw_r, fw_nxt;
  logic              pg_r, pg_nxt;
  logic [5:0]        pr_r, pr_nxt;         // saturated precision
  logic              neg_r, neg_nxt;
  logic              upper_r, upper_nxt;
  logic              pfx_r, pfx_nxt;

  // shared digit unit
  logic [3:0]             digit_store_r [DIGIT_STORE_DEPTH];
  logic [3:0]             store_nxt     [DIGIT_STORE_DEPTH];
  logic [3:0]             adj           [DIGIT_STORE_DEPTH];
  logic [3:0]             dabble        [DIGIT_STORE_DEPTH];
  logic [DIGIT_CNT_W-1:0] dc_r, dc_nxt;    // digit count
  logic [6:0]             bit_cnt_r, bit_cnt_nxt;

  // layout
  logic [6:0] pad_r, pad_nxt;
  logic [6:0] pz_r, pz_nxt;                // precision zeros
  logic [6:0] body_r, body_nxt;
  logic       sgn_r, sgn_nxt;
  logic [6:0] b1_r, b2_r, b3_r, b5_r, b6_r, total_r, dtop_r;
  logic [6:0] b1_nxt, b2_nxt, b3_nxt, b5_nxt, b6_nxt, total_nxt, dtop_nxt;
  logic [6:0] pos_r, pos_nxt;              // emit position

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic [6:0] out_count_r, out_count_nxt;

  // combinational helpers
  logic        in_xfer, out_xfer;
  logic [63:0] masked, negated, mag, vsel, aligned;
  logic        sign_bit, is_neg, is_dec, suppress;
  logic [6:0]  nbits;
  logic [63:0] hex_shift;
  logic [3:0]  hex_digit;
  logic        prec_pad;
  logic [6:0]  dc7, pr7, content, pad_c, pz_c, body_c;
  logic        left, zero_pad, sgn_c;
  logic [7:0]  sign_ch, emit_ch;
  logic        emit_last;
  logic [DIGIT_IDX_W-1:0] rd_idx;
  logic [6:0]  rd_off;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_last       = out_last_r;
  assign out_char_count = out_count_r;

  // value preparation: truncate, sign, magnitude
  always_comb begin
    masked = mask_size(work_r, sc_r);
    unique case (sc_r)
      SC_8:    sign_bit = work_r[7];
      SC_16:   sign_bit = work_r[15];
      SC_32:   sign_bit = work_r[31];
      default: sign_bit = work_r[63];
    endcase
    is_neg  = (mode_r == MODE_SDEC) && sign_bit;
    negated = mask_size(64'd0 - masked, sc_r);
    mag     = is_neg ? negated : masked;
    if (mode_r == MODE_PTR) begin
      vsel = {32'b0, work_r[31:0]};
    end else if (mode_r == MODE_CHAR) begin
      vsel = {56'b0, work_r[7:0]};
    end else begin
      vsel = mag;
    end
    // decimal shifts msb first, so left-align the operand
    unique case (sc_r)
      SC_8:    begin nbits = 7'd8;  aligned = {vsel[7:0], 56'b0};  end
      SC_16:   begin nbits = 7'd16; aligned = {vsel[15:0], 48'b0}; end
      SC_32:   begin nbits = 7'd32; aligned = {vsel[31:0], 32'b0}; end
      default: begin nbits = 7'd64; aligned = vsel;                 end
    endcase
    suppress = (mode_r <= MODE_HEXU) && pg_r && (pr_r == 6'd0) && (vsel == 64'd0);
  end

  // add-3 and shift step of the decimal digit unit
  always_comb begin
    for (int k = 0; k < DIGIT_STORE_DEPTH; k++) begin
      adj[k] = (digit_store_r[k] >= 4'd5) ? digit_store_r[k] + 4'd3 : digit_store_r[k];
    end
    dabble[0] = {adj[0][2:0], work_r[63]};
    for (int k = 1; k < DIGIT_STORE_DEPTH; k++) begin
      dabble[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  assign is_dec = (mode_r == MODE_SDEC) || (mode_r == MODE_UDEC);

  // octal / hex digit step
  always_comb begin
    if (mode_r == MODE_OCT) begin
      hex_digit = {1'b0, work_r[2:0]};
      hex_shift = work_r >> 3;
    end else begin
      hex_digit = work_r[3:0];
      hex_shift = work_r >> 4;
    end
  end

  // sizing terms, all from registered state
  always_comb begin
    dc7      = {{(7-DIGIT_CNT_W){1'b0}}, dc_r};
    pr7      = {1'b0, pr_r};
    prec_pad = (mode_r <= MODE_OCT) && pg_r && (pr7 > dc7);
    left     = flags_r[FLAG_LEFT];
    zero_pad = flags_r[FLAG_ZERO] && !left;
    sgn_c    = neg_r || flags_r[FLAG_PLUS] || flags_r[FLAG_SPACE];
    pz_c     = prec_pad ? pr7 - dc7 : 7'd0;
    // digits only, precision zeros counted apart
    body_c   = (mode_r == MODE_CHAR) ? 7'd1 : dc7;
    content  = {6'b0, sgn_c} + (pfx_r ? 7'd2 : 7'd0) + pz_c + body_c;
    pad_c    = (wg_r && ({1'b0, fw_r} > content)) ? {1'b0, fw_r} - content : 7'd0;
  end

  // character at the current emit position
  always_comb begin
    if (neg_r) begin
      sign_ch = CH_MINUS;
    end else if (flags_r[FLAG_PLUS]) begin
      sign_ch = CH_PLUS;
    end else begin
      sign_ch = CH_SPACE;
    end
    rd_off = dtop_r - pos_r;
    rd_idx = rd_off[DIGIT_IDX_W-1:0];
    priority if (pos_r < b1_r) begin
      emit_ch = CH_SPACE;
    end else if (pos_r < b2_r) begin
      emit_ch = sign_ch;
    end else if (pos_r < b3_r) begin
      emit_ch = (pos_r == b2_r) ? CH_ZERO : CH_X;
    end else if (pos_r < b5_r) begin
      emit_ch = CH_ZERO;
    end else if (pos_r < b6_r) begin
      emit_ch = (mode_r == MODE_CHAR) ? work_r[7:0] : digit_char(digit_store_r[rd_idx], upper_r);
    end else begin
      emit_ch = CH_SPACE;
    end
    emit_last = (pos_r == total_r - 7'd1);
  end

  // sequencer and datapath next state
  always_comb begin
    state_nxt   = state_r;
    work_nxt    = work_r;
    mode_nxt    = mode_r;
    sc_nxt      = sc_r;
    flags_nxt   = flags_r;
    wg_nxt      = wg_r;
    fw_nxt      = fw_r;
    pg_nxt      = pg_r;
    pr_nxt      = pr_r;
    neg_nxt     = neg_r;
    upper_nxt   = upper_r;
    pfx_nxt     = pfx_r;
    store_nxt   = digit_store_r;
    dc_nxt      = dc_r;
    bit_cnt_nxt = bit_cnt_r;
    pad_nxt     = pad_r;
    pz_nxt      = pz_r;
    body_nxt    = body_r;
    sgn_nxt     = sgn_r;
    b1_nxt      = b1_r;
    b2_nxt      = b2_r;
    b3_nxt      = b3_r;
    b5_nxt      = b5_r;
    b6_nxt      = b6_r;
    total_nxt   = total_r;
    dtop_nxt    = dtop_r;
    pos_nxt     = pos_r;
    // output register drains on a transfer unless refilled below
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_mode != MODE_UNUSED)) begin
          work_nxt  = in_value;
          mode_nxt  = in_mode;
          sc_nxt    = in_size_class;
          flags_nxt = in_flag_bits;
          wg_nxt    = in_width_given;
          fw_nxt    = (in_field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : in_field_width;
          pg_nxt    = in_precision_given;
          pr_nxt    = (in_precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : in_precision;
          state_nxt = ST_LOAD;
        end
      end

      ST_LOAD: begin
        neg_nxt     = is_neg;
        upper_nxt   = (mode_r == MODE_HEXU) || (mode_r == MODE_PTR);
        pfx_nxt     = (mode_r == MODE_PTR) ||
                      (((mode_r == MODE_HEXL) || (mode_r == MODE_HEXU)) && flags_r[FLAG_ALT]);
        dc_nxt      = '0;
        bit_cnt_nxt = nbits;
        if ((mode_r == MODE_CHAR) || suppress) begin
          work_nxt  = vsel;
          state_nxt = ST_SIZE;
        end else if (is_dec) begin
          work_nxt = aligned;
          for (int k = 0; k < DIGIT_STORE_DEPTH; k++) begin
            store_nxt[k] = 4'd0;
          end
          state_nxt = ST_CONV;
        end else begin
          work_nxt  = vsel;
          state_nxt = ST_CONV;
        end
      end

      ST_CONV: begin
        if (is_dec) begin
          // one binary digit per cycle into the decimal digit store
          store_nxt   = dabble;
          work_nxt    = {work_r[62:0], 1'b0};
          bit_cnt_nxt = bit_cnt_r - 7'd1;
          if ((dc_r < DIGIT_CNT_W'(DIGIT_STORE_DEPTH)) &&
              (dabble[dc_r[DIGIT_IDX_W-1:0]] != 4'd0)) begin
            dc_nxt = dc_r + DIGIT_CNT_W'(1);
          end
          if (bit_cnt_r == 7'd1) begin
            if (dc_nxt == '0) begin
              dc_nxt = DIGIT_CNT_W'(1);
            end
            state_nxt = ST_SIZE;
          end
        end else begin
          // one octal or hex digit per cycle, least significant first
          store_nxt[dc_r[DIGIT_IDX_W-1:0]] = hex_digit;
          work_nxt = hex_shift;
          dc_nxt   = dc_r + DIGIT_CNT_W'(1);
          if ((hex_shift == 64'd0) || (dc_nxt == DIGIT_CNT_W'(DIGIT_STORE_DEPTH))) begin
            state_nxt = ST_SIZE;
          end
        end
      end

      ST_SIZE: begin
        sgn_nxt   = sgn_c;
        body_nxt  = body_c;
        pz_nxt    = pz_c;
        pad_nxt   = pad_c;
        state_nxt = ST_BOUND;
      end

      ST_BOUND: begin
        // segment boundaries: lpad, sign, prefix, zero pad, precision zeros, body, rpad
        b1_nxt    = (!left && !zero_pad) ? pad_r : 7'd0;
        b2_nxt    = b1_nxt + {6'b0, sgn_r};
        b3_nxt    = b2_nxt + (pfx_r ? 7'd2 : 7'd0);
        b5_nxt    = b3_nxt + (zero_pad ? pad_r : 7'd0) + pz_r;
        b6_nxt    = b5_nxt + body_r;
        total_nxt = b6_nxt + (left ? pad_r : 7'd0);
        dtop_nxt  = b5_nxt + dc7 - 7'd1;
        pos_nxt   = 7'd0;
        state_nxt = (total_nxt == 7'd0) ? ST_IDLE : ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = emit_ch;
          out_last_nxt  = emit_last;
          out_count_nxt = emit_last ? total_r : 7'd0;
          pos_nxt       = pos_r + 7'd1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      dc_r        <= '0;
      work_r      <= '0;
      pos_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      dc_r        <= dc_nxt;
      work_r      <= work_nxt;
      pos_r       <= pos_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    sc_r        <= sc_nxt;
    flags_r     <= flags_nxt;
    wg_r        <= wg_nxt;
    fw_r        <= fw_nxt;
    pg_r        <= pg_nxt;
    pr_r        <= pr_nxt;
    neg_r       <= neg_nxt;
    upper_r     <= upper_nxt;
    pfx_r       <= pfx_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    pad_r       <= pad_nxt;
    pz_r        <= pz_nxt;
    body_r      <= body_nxt;
    sgn_r       <= sgn_nxt;
    b1_r        <= b1_nxt;
    b2_r        <= b2_nxt;
    b3_r        <= b3_nxt;
    b5_r        <= b5_nxt;
    b6_r        <= b6_nxt;
    total_r     <= total_nxt;
    dtop_r      <= dtop_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
  end

  // digit store
  always_ff @(posedge clk) begin
    digit_store_r <= store_nxt;
  end

  // checks
  `AST_IMP(a_emit_in_range, state_r == ST_EMIT, pos_r < total_r,
           "emit position past the end of the conversion")
  `AST_IMP(a_conv_count, state_r == ST_CONV, dc_r < DIGIT_CNT_W'(DIGIT_STORE_DEPTH),
           "digit count overran the digit store")
  `AST_NXT(a_no_gap, out_xfer && !out_last_r, out_valid_r,
           "gap inside the characters of one conversion")
  `AST_NXT(a_busy_after_accept, in_xfer && (in_mode != MODE_UNUSED), in_stall,
           "conversion accepted but block not busy")
  `AST_IMP(a_last_count, out_valid_r && out_last_r, out_count_r != 7'd0,
           "final character without a character count")

endmodule
